### design/tpm_pkg.sv
// Shared constants, codes and control types of the timer pool manager.
package tpm_pkg;

  localparam int unsigned TIMERS      = 16;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned IDX_W       = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned SWP_W       = IDX_W + 1;
  localparam int unsigned RUN_W       = $clog2(TIMERS + 1);
  localparam int unsigned MAX_EVENTS  = 16;
  localparam int unsigned EVC_W       = $clog2(MAX_EVENTS + 1);
  localparam logic [4:0]  MAX_ARMED_RESET = 5'd16;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ARM       = 3'd1,
    CMD_FORCE_ARM = 3'd2,
    CMD_CANCEL    = 3'd3,
    CMD_SUSPEND   = 3'd4,
    CMD_RESUME    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_ALREADY       = 3'd1,
    ST_NOT_ACTIVE    = 3'd2,
    ST_NOT_RUNNING   = 3'd3,
    ST_NOT_SUSPENDED = 3'd4,
    ST_SATURATED     = 3'd5,
    ST_EXPIRED       = 3'd6,
    ST_TICK_IDLE     = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    TS_STOPPED   = 2'd0,
    TS_RUNNING   = 2'd1,
    TS_SUSPENDED = 2'd2
  } tstate_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SWEEP = 2'd2,
    S_TEND  = 2'd3
  } fsm_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic is_tick;
    logic out_free;
    logic sweep_done;
  } sts_t;

endpackage

### design/tpm_if.sv
// Handshake channels of the timer pool manager: command, result and configuration.
interface tpm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  timer_id;
  logic [31:0] delay_ticks;
  logic        retrigger;

  modport source (output valid, command, timer_id, delay_ticks, retrigger, input ready);
  modport sink   (input valid, command, timer_id, delay_ticks, retrigger, output ready);
endinterface

interface tpm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  event_timer;
  logic [31:0] remaining_ticks;
  logic        last;

  modport source (output valid, status, event_timer, remaining_ticks, last, input ready);
  modport sink   (input valid, status, event_timer, remaining_ticks, last, output ready);
endinterface

interface tpm_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] max_armed;

  modport source (output valid, max_armed, input ready);
  modport sink   (input valid, max_armed, output ready);
endinterface

### design/tpm_ctrl.sv
// Sequencer of the timer pool manager: command execution and tick sweep.
module tpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tpm_pkg::sts_t sts_i,
  output tpm_pkg::ctl_t ctl_o
);

  tpm_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.is_tick ? tpm_pkg::S_SWEEP : tpm_pkg::S_EXEC;
        end
      end
      tpm_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = tpm_pkg::S_IDLE;
        end
      end
      tpm_pkg::S_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = tpm_pkg::S_TEND;
        end
      end
      tpm_pkg::S_TEND: begin
        if (sts_i.out_free) begin
          state_d = tpm_pkg::S_IDLE;
        end
      end
      default: state_d = tpm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    ctl_o        = '0;
    case (state_q)
      tpm_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
      end
      tpm_pkg::S_EXEC:  ctl_o.exec   = sts_i.out_free;
      tpm_pkg::S_SWEEP: ctl_o.sweep  = 1'b1;
      tpm_pkg::S_TEND:  ctl_o.finish = sts_i.out_free;
      default: ctl_o = '0;
    endcase
  end

endmodule

### design/tpm_dp.sv
// Datapath of the timer pool manager: timer stores, running count and result register.
module tpm_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpm_pkg::ctl_t ctl_i,
  output tpm_pkg::sts_t sts_o,
  input  logic [2:0]    command_i,
  input  logic [3:0]    timer_id_i,
  input  logic [31:0]   delay_ticks_i,
  input  logic          retrigger_i,
  input  logic          cfg_valid_i,
  input  logic [4:0]    cfg_max_armed_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    out_status_o,
  output logic [3:0]    out_event_timer_o,
  output logic [31:0]   out_remaining_o,
  output logic          out_last_o
);

  localparam int unsigned CW    = tpm_pkg::COUNT_WIDTH;
  localparam int unsigned IW    = tpm_pkg::IDX_W;
  localparam int unsigned SW    = tpm_pkg::SWP_W;
  localparam int unsigned RW    = tpm_pkg::RUN_W;
  localparam int unsigned EW    = tpm_pkg::EVC_W;

  // Latched command word.
  logic [2:0]    cmd_q;
  logic [3:0]    id_q;
  logic [CW-1:0] delay_q;
  logic          retrig_q;

  // Timer stores.
  tpm_pkg::tstate_e st_q [tpm_pkg::TIMERS];
  logic [CW-1:0]    rem_mem_q [tpm_pkg::TIMERS];
  logic [CW-1:0]    per_mem_q [tpm_pkg::TIMERS];
  logic             ren_mem_q [tpm_pkg::TIMERS];
  logic [CW-1:0]    rem_rd_q, per_rd_q;
  logic             ren_rd_q;

  logic [RW-1:0] run_q;
  logic [4:0]    max_q;

  // Sweep state.
  logic [SW-1:0] rd_idx_q;
  logic          proc_vld_q;
  logic [IW-1:0] proc_idx_q;
  logic          pend_vld_q;
  logic [IW-1:0] pend_idx_q;
  logic [EW-1:0] evc_q;

  // Result register.
  logic        out_vld_q;
  logic [2:0]  out_st_q;
  logic [3:0]  out_id_q;
  logic [31:0] out_rem_q;
  logic        out_last_q;

  logic             out_free;
  logic [IW-1:0]    id_addr;
  logic [IW-1:0]    sel_idx;
  tpm_pkg::tstate_e cur_st;
  logic             id_ok;
  logic             rd_more, rd_en;
  logic [IW-1:0]    raddr;

  logic             p_run, p_exp, p_emit, push_pend, stall, adv;
  logic [RW-1:0]    run_dec_p, run_dec_id;
  logic             reload_ok;

  tpm_pkg::status_e ex_status;
  logic             ex_st_we, ex_mem_we;
  tpm_pkg::tstate_e ex_st_new;
  logic [RW-1:0]    ex_run;
  logic [31:0]      ex_rem;

  assign out_free = !out_vld_q || out_ready_i;
  assign id_addr  = IW'(id_q);
  assign id_ok    = 32'(id_q) < tpm_pkg::TIMERS;
  assign sel_idx  = ctl_i.sweep ? proc_idx_q : id_addr;
  assign cur_st   = st_q[sel_idx];

  // Sweep: read slot rd_idx while slot proc_idx is evaluated.
  assign rd_more   = rd_idx_q != SW'(tpm_pkg::TIMERS);
  assign p_run     = proc_vld_q && (cur_st == tpm_pkg::TS_RUNNING);
  assign p_exp     = p_run && (rem_rd_q <= CW'(1));
  assign p_emit    = p_exp && (evc_q < EW'(tpm_pkg::MAX_EVENTS));
  assign push_pend = p_emit && pend_vld_q;
  assign stall     = push_pend && !out_free;
  assign adv       = ctl_i.sweep && !stall;
  assign run_dec_p = run_q - RW'(run_q != '0);
  assign reload_ok = ren_rd_q && (32'(run_dec_p) < 32'(max_q));

  assign rd_en = ctl_i.accept || (adv && rd_more);
  assign raddr = ctl_i.accept ? IW'(timer_id_i) : rd_idx_q[IW-1:0];

  assign sts_o.is_tick    = command_i == tpm_pkg::CMD_TICK;
  assign sts_o.out_free   = out_free;
  assign sts_o.sweep_done = !rd_more && !proc_vld_q;

  // Command execution for the latched word.
  always_comb begin
    ex_status  = tpm_pkg::ST_OK;
    ex_st_we   = 1'b0;
    ex_st_new  = tpm_pkg::TS_STOPPED;
    ex_run     = run_q;
    ex_mem_we  = 1'b0;
    ex_rem     = '0;
    run_dec_id = run_q - RW'((cur_st == tpm_pkg::TS_RUNNING) && (run_q != '0));
    case (cmd_q)
      tpm_pkg::CMD_ARM: begin
        if (!id_ok) begin
          ex_status = tpm_pkg::ST_NOT_ACTIVE;
        end else if (cur_st != tpm_pkg::TS_STOPPED) begin
          ex_status = tpm_pkg::ST_ALREADY;
        end else if (32'(run_q) >= 32'(max_q)) begin
          ex_status = tpm_pkg::ST_SATURATED;
        end else begin
          ex_st_we  = 1'b1;
          ex_st_new = tpm_pkg::TS_RUNNING;
          ex_run    = run_q + RW'(1);
          ex_mem_we = 1'b1;
        end
      end
      tpm_pkg::CMD_FORCE_ARM: begin
        if (!id_ok) begin
          ex_status = tpm_pkg::ST_NOT_ACTIVE;
        end else if (32'(run_dec_id) >= 32'(max_q)) begin
          ex_status = tpm_pkg::ST_SATURATED;
          ex_st_we  = 1'b1;
          ex_st_new = tpm_pkg::TS_STOPPED;
          ex_run    = run_dec_id;
        end else begin
          ex_st_we  = 1'b1;
          ex_st_new = tpm_pkg::TS_RUNNING;
          ex_run    = run_dec_id + RW'(1);
          ex_mem_we = 1'b1;
        end
      end
      tpm_pkg::CMD_CANCEL: begin
        if (!id_ok || cur_st == tpm_pkg::TS_STOPPED) begin
          ex_status = tpm_pkg::ST_NOT_ACTIVE;
        end else begin
          ex_st_we  = 1'b1;
          ex_st_new = tpm_pkg::TS_STOPPED;
          ex_run    = run_dec_id;
        end
      end
      tpm_pkg::CMD_SUSPEND: begin
        if (!id_ok) begin
          ex_status = tpm_pkg::ST_NOT_ACTIVE;
        end else if (cur_st != tpm_pkg::TS_RUNNING) begin
          ex_status = tpm_pkg::ST_NOT_RUNNING;
        end else begin
          ex_st_we  = 1'b1;
          ex_st_new = tpm_pkg::TS_SUSPENDED;
          ex_run    = run_dec_id;
          ex_rem    = 32'(rem_rd_q);
        end
      end
      tpm_pkg::CMD_RESUME: begin
        if (!id_ok) begin
          ex_status = tpm_pkg::ST_NOT_ACTIVE;
        end else if (cur_st != tpm_pkg::TS_SUSPENDED) begin
          ex_status = tpm_pkg::ST_NOT_SUSPENDED;
        end else if (32'(run_q) >= 32'(max_q)) begin
          ex_status = tpm_pkg::ST_SATURATED;
        end else begin
          ex_st_we  = 1'b1;
          ex_st_new = tpm_pkg::TS_RUNNING;
          ex_run    = run_q + RW'(1);
        end
      end
      default: ex_status = tpm_pkg::ST_TICK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q    <= command_i;
      id_q     <= timer_id_i;
      delay_q  <= CW'(delay_ticks_i);
      retrig_q <= retrigger_i;
    end
  end

  // Memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && ex_mem_we) begin
      rem_mem_q[id_addr] <= delay_q;
      per_mem_q[id_addr] <= delay_q;
      ren_mem_q[id_addr] <= retrig_q;
    end else if (adv && p_run) begin
      rem_mem_q[proc_idx_q] <= p_exp ? per_rd_q : rem_rd_q - CW'(1);
    end
    if (rd_en) begin
      rem_rd_q <= rem_mem_q[raddr];
      per_rd_q <= per_mem_q[raddr];
      ren_rd_q <= ren_mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tpm_pkg::TIMERS; i++) begin
        st_q[i] <= tpm_pkg::TS_STOPPED;
      end
      run_q <= '0;
      max_q <= tpm_pkg::MAX_ARMED_RESET;
    end else begin
      if (ctl_i.exec && ex_st_we) begin
        st_q[id_addr] <= ex_st_new;
      end else if (adv && p_exp) begin
        st_q[proc_idx_q] <= reload_ok ? tpm_pkg::TS_RUNNING : tpm_pkg::TS_STOPPED;
      end
      if (ctl_i.exec) begin
        run_q <= ex_run;
      end else if (adv && p_exp && !reload_ok) begin
        run_q <= run_dec_p;
      end
      if (cfg_valid_i) begin
        max_q <= cfg_max_armed_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
      evc_q      <= '0;
    end else if (ctl_i.accept) begin
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      evc_q      <= '0;
    end else begin
      if (adv) begin
        proc_vld_q <= rd_more;
        if (rd_more) begin
          proc_idx_q <= rd_idx_q[IW-1:0];
          rd_idx_q   <= rd_idx_q + SW'(1);
        end
        if (p_emit) begin
          pend_vld_q <= 1'b1;
          pend_idx_q <= proc_idx_q;
          evc_q      <= evc_q + EW'(1);
        end
      end
      if (ctl_i.finish) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.exec || (adv && push_pend) || ctl_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      out_st_q   <= ex_status;
      out_id_q   <= id_q;
      out_rem_q  <= ex_rem;
      out_last_q <= 1'b1;
    end else if (adv && push_pend) begin
      out_st_q   <= tpm_pkg::ST_EXPIRED;
      out_id_q   <= 4'(pend_idx_q);
      out_rem_q  <= '0;
      out_last_q <= 1'b0;
    end else if (ctl_i.finish) begin
      out_st_q   <= pend_vld_q ? tpm_pkg::ST_EXPIRED : tpm_pkg::ST_TICK_IDLE;
      out_id_q   <= pend_vld_q ? 4'(pend_idx_q) : 4'd0;
      out_rem_q  <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_status_o      = out_st_q;
  assign out_event_timer_o = out_id_q;
  assign out_remaining_o   = out_rem_q;
  assign out_last_o        = out_last_q;

endmodule

### design/timer_pool_manager.sv
// Timer pool manager top level: command, result and configuration channels.
// Sequence: a timer command is latched on accept and then executed into the result register;
//   a tick sweeps the timer slots, one slot per cycle unless an expiry waits on a stalled
//   result channel, and then loads its final word. A new command word is taken only once
//   the final result word of the last one is loaded, which a stalled result channel delays.
// Reset: rst_ni clears all timers to stopped, the running count to zero and the
//   limit to 16; count, period and reload stores keep no reset value.
module timer_pool_manager (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpm_in_if.sink     in_i,
  tpm_out_if.source  out_o,
  tpm_cfg_if.sink    cfg_i
);

  tpm_pkg::ctl_t ctl;
  tpm_pkg::sts_t sts;

  // The limit register takes a word in any cycle.
  assign cfg_i.ready = 1'b1;

  // Sequencer: accept a word only while idle, then run the command or the sweep.
  tpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Datapath: hold timer state, advance counts on tick, drive the result register.
  tpm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .command_i         (in_i.command),
    .timer_id_i        (in_i.timer_id),
    .delay_ticks_i     (in_i.delay_ticks),
    .retrigger_i       (in_i.retrigger),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_max_armed_i   (cfg_i.max_armed),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_status_o      (out_o.status),
    .out_event_timer_o (out_o.event_timer),
    .out_remaining_o   (out_o.remaining_ticks),
    .out_last_o        (out_o.last)
  );

endmodule

### design/tpm_checker.sv
// Port-level checks of the timer pool manager and their binding to the top level.
module tpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_status_i,
  input logic [3:0]  out_event_timer_i,
  input logic [31:0] out_remaining_i,
  input logic        out_last_i
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_status_i, out_event_timer_i, out_remaining_i, out_last_i}))
    else $error("result word changed while stalled");

  // One word at a time: busy right after an accept.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command channel ready right after an accept");

  // No new word while results of the current one are still due.
  a_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("command channel ready in the middle of a result burst");

  // Return to idle only with the final result word loaded.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i && out_last_i)
    else $error("idle without a final result word");

endmodule

bind timer_pool_manager tpm_checker u_tpm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_event_timer_i (out_o.event_timer),
  .out_remaining_i   (out_o.remaining_ticks),
  .out_last_i        (out_o.last)
);

### tb/timer_pool_manager_check.sv
// Result checker for the timer pool manager: tracks timer state and compares result words.
module timer_pool_manager_check
  import tpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [2:0]  command_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] delay_ticks_i,
  input  logic        retrigger_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  event_timer_i,
  input  logic [31:0] remaining_ticks_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [4:0]  max_armed_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  timer;
    logic [31:0] ticks_left;
    logic        last;
  } timer_result_t;

  timer_result_t              due_results_q[$];
  tstate_e                    timer_state[TIMERS];
  logic [COUNT_WIDTH-1:0]     count_left[TIMERS];
  logic [COUNT_WIDTH-1:0]     period[TIMERS];
  logic                       reload_on[TIMERS];
  int unsigned                running;
  logic [4:0]                 limit;
  int                         errors;

  function automatic void clear_pool();
    for (int i = 0; i < TIMERS; i++) begin
      timer_state[i] = TS_STOPPED;
      count_left[i]  = '0;
      period[i]      = '0;
      reload_on[i]   = 1'b0;
    end
    running = 0;
    limit   = MAX_ARMED_RESET;
  endfunction

  function automatic void push_result(status_e st, logic [3:0] t, logic [31:0] ticks, logic lst);
    due_results_q.push_back(timer_result_t'{status: st, timer: t, ticks_left: ticks, last: lst});
  endfunction

  function automatic void halt_timer(int unsigned t);
    if (timer_state[t] == TS_RUNNING && running > 0) running--;
    timer_state[t] = TS_STOPPED;
  endfunction

  function automatic status_e launch_timer(int unsigned t, logic [COUNT_WIDTH-1:0] cnt);
    if (running >= limit) return ST_SATURATED;
    timer_state[t] = TS_RUNNING;
    count_left[t]  = cnt;
    running++;
    return ST_OK;
  endfunction

  // Count every running timer down; expired ones report in ascending order.
  function automatic void sweep_tick();
    int unsigned fired_q[$];
    for (int unsigned i = 0; i < TIMERS; i++) begin
      if (timer_state[i] != TS_RUNNING) continue;
      if (count_left[i] > 1) begin
        count_left[i]--;
        continue;
      end
      halt_timer(i);
      if (reload_on[i]) void'(launch_timer(i, period[i]));
      fired_q.push_back(i);
    end
    if (fired_q.size() == 0) begin
      push_result(ST_TICK_IDLE, 4'd0, '0, 1'b1);
    end else begin
      foreach (fired_q[k])
        push_result(ST_EXPIRED, 4'(fired_q[k]), '0, k == fired_q.size() - 1);
    end
  endfunction

  function automatic void apply_timer_command(logic [2:0] cmd, logic [3:0] id,
                                              logic [31:0] delay, logic rt);
    status_e     st;
    logic [31:0] left;
    st   = ST_OK;
    left = '0;
    if (cmd == CMD_TICK) begin
      sweep_tick();
      return;
    end
    case (cmd)
      CMD_ARM: begin
        if (timer_state[id] != TS_STOPPED) begin
          st = ST_ALREADY;
        end else begin
          st = launch_timer(id, delay);
          if (st == ST_OK) begin
            period[id]    = delay;
            reload_on[id] = rt;
          end
        end
      end
      CMD_FORCE_ARM: begin
        halt_timer(id);
        st = launch_timer(id, delay);
        if (st == ST_OK) begin
          period[id]    = delay;
          reload_on[id] = rt;
        end
      end
      CMD_CANCEL: begin
        if (timer_state[id] == TS_STOPPED) st = ST_NOT_ACTIVE;
        else halt_timer(id);
      end
      CMD_SUSPEND: begin
        if (timer_state[id] != TS_RUNNING) begin
          st = ST_NOT_RUNNING;
        end else begin
          halt_timer(id);
          timer_state[id] = TS_SUSPENDED;
          left = count_left[id];
        end
      end
      CMD_RESUME: begin
        if (timer_state[id] != TS_SUSPENDED) st = ST_NOT_SUSPENDED;
        else st = launch_timer(id, count_left[id]);
      end
      default: st = ST_TICK_IDLE;
    endcase
    push_result(st, id, left, 1'b1);
  endfunction

  always @(posedge clk_i) begin : watch_channels
    timer_result_t want;
    if (!rst_ni) begin
      clear_pool();
      due_results_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit = max_armed_i;
      if (cmd_valid_i && cmd_ready_i)
        apply_timer_command(command_i, timer_id_i, delay_ticks_i, retrigger_i);
      if (res_valid_i && res_ready_i) begin
        if (due_results_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result word: status %0d timer %0d ticks %0h last %0b",
                     status_i, event_timer_i, remaining_ticks_i, last_i);
        end else begin
          want = due_results_q.pop_front();
          if (status_i !== want.status || event_timer_i !== want.timer ||
              remaining_ticks_i !== want.ticks_left || last_i !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("result mismatch: expected %0d/%0d/%0h/%0b, got %0d/%0d/%0h/%0b",
                       want.status, want.timer, want.ticks_left, want.last,
                       status_i, event_timer_i, remaining_ticks_i, last_i);
          end
        end
      end
      fail_count_o <= errors;
      pending_o    <= due_results_q.size();
    end
  end

endmodule

### tb/timer_pool_manager_tb.sv
// Testbench top for the timer pool manager: clock, reset, stimulus, stalls and verdict.
module timer_pool_manager_tb;
  import tpm_pkg::*;

  localparam int RESET_CYCLES = 10;
  // A tick may sweep every slot before its first result; leave room for that after draining.
  localparam int DRAIN_CYCLES = TIMERS + 8;
  // Longest quiet stretch allowed: a full sweep plus long result stalls and sender gaps,
  // taken many times over.
  localparam int IDLE_LIMIT   = 1500;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 75;

  // Command codes outside the defined set; the block must answer them as no-ops.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [31:0] DELAY_MAX    = 32'hFFFF_FFFF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tpm_in_if  cmd_if ();
  tpm_out_if res_if ();
  tpm_cfg_if cfg_if ();

  int mismatch_count;
  int due_count;

  int          burst_left;
  int          id_span;
  bit          cmd_live;
  int unsigned stuck_cycles;
  logic [4:0]  phase_limits[PHASES];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  timer_pool_manager u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  timer_pool_manager_check u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cmd_valid_i       (cmd_if.valid),
    .cmd_ready_i       (cmd_if.ready),
    .command_i         (cmd_if.command),
    .timer_id_i        (cmd_if.timer_id),
    .delay_ticks_i     (cmd_if.delay_ticks),
    .retrigger_i       (cmd_if.retrigger),
    .res_valid_i       (res_if.valid),
    .res_ready_i       (res_if.ready),
    .status_i          (res_if.status),
    .event_timer_i     (res_if.event_timer),
    .remaining_ticks_i (res_if.remaining_ticks),
    .last_i            (res_if.last),
    .cfg_valid_i       (cfg_if.valid),
    .cfg_ready_i       (cfg_if.ready),
    .max_armed_i       (cfg_if.max_armed),
    .fail_count_o      (mismatch_count),
    .pending_o         (due_count)
  );

  // Watchdog: count cycles in which no channel moves a word, end the run at the limit.
  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("timer_pool_manager_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result receiver: hold each stall mode for a random stretch, then pick another, so that
  // stalls land on every phase of a tick sweep, with fully open stretches between.
  initial begin : result_stalls
    int mode;
    int mode_left;
    int hold_left;
    int step;
    mode_left = 0;
    hold_left = 0;
    step      = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      step++;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        2: res_if.ready <= (step % 5) < 3;
        default: begin
          if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(4, 24);
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Close a burst when its count runs out: drop valid for a random gap, or
  // roll straight into the next burst with no gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        cmd_live = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Present one command word and hold it until the block takes it.
  task automatic send_command(input logic [2:0] cmd, input logic [3:0] id,
                              input logic [31:0] delay, input logic rt);
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= cmd;
    cmd_if.timer_id    <= id;
    cmd_if.delay_ticks <= delay;
    cmd_if.retrigger   <= rt;
    cmd_live = 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    pace_sender();
  endtask

  // Drain every expected result, then write the limit register.
  task automatic set_limit(input logic [4:0] value);
    if (cmd_live) begin
      cmd_if.valid <= 1'b0;
      cmd_live = 1'b0;
    end
    do @(posedge clk); while (due_count != 0);
    cfg_if.valid     <= 1'b1;
    cfg_if.max_armed <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Random command with content biased toward live timers: short delays so
  // ticks expire them often, ids drawn from a narrow span so commands collide.
  task automatic random_command();
    int          pick;
    int          shape;
    logic [2:0]  cmd;
    logic [31:0] delay;
    pick = $urandom_range(0, 99);
    if (pick < 30)      cmd = CMD_TICK;
    else if (pick < 50) cmd = CMD_ARM;
    else if (pick < 60) cmd = CMD_FORCE_ARM;
    else if (pick < 70) cmd = CMD_CANCEL;
    else if (pick < 82) cmd = CMD_SUSPEND;
    else if (pick < 96) cmd = CMD_RESUME;
    else                cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    shape = $urandom_range(0, 9);
    if (shape < 7)       delay = $urandom_range(0, 4);
    else if (shape == 7) delay = $urandom_range(5, 40);
    else if (shape == 8) delay = $urandom();
    else                 delay = DELAY_MAX;
    send_command(cmd, 4'($urandom_range(0, id_span)), delay, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    cmd_if.valid       <= 1'b0;
    cmd_if.command     <= CMD_TICK;
    cmd_if.timer_id    <= '0;
    cmd_if.delay_ticks <= '0;
    cmd_if.retrigger   <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.max_armed   <= '0;
    cmd_live   = 1'b0;
    burst_left = 1;
    id_span    = TIMERS - 1;
    phase_limits = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd16};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command and every status but saturated, extreme ids and delays, at the reset limit.
    send_command(CMD_TICK,      4'd0,  32'd0,     1'b0);  // nothing running: idle tick
    send_command(CMD_ARM,       4'd0,  32'd0,     1'b0);  // zero delay fires on next tick
    send_command(CMD_ARM,       4'd15, DELAY_MAX, 1'b1);
    send_command(CMD_ARM,       4'd0,  32'd5,     1'b0);  // already running
    send_command(CMD_CANCEL,    4'd3,  32'd0,     1'b0);  // stopped: not active
    send_command(CMD_SUSPEND,   4'd3,  32'd0,     1'b0);  // stopped: not running
    send_command(CMD_RESUME,    4'd0,  32'd0,     1'b0);  // running: not suspended
    send_command(CMD_ARM,       4'd1,  32'd1,     1'b1);
    send_command(CMD_TICK,      4'd7,  DELAY_MAX, 1'b1);  // two expiries, one reload
    send_command(CMD_TICK,      4'd0,  32'd0,     1'b0);
    send_command(CMD_SUSPEND,   4'd15, 32'd0,     1'b0);  // reports ticks left
    send_command(CMD_ARM,       4'd15, 32'd9,     1'b0);  // suspended counts as active
    send_command(CMD_RESUME,    4'd15, 32'd0,     1'b0);
    send_command(CMD_SUSPEND,   4'd15, 32'd0,     1'b0);
    send_command(CMD_CANCEL,    4'd15, 32'd0,     1'b0);  // cancel from suspended
    send_command(CMD_FORCE_ARM, 4'd1,  32'd2,     1'b0);  // restart a running timer
    send_command(CMD_FORCE_ARM, 4'd2,  32'd3,     1'b1);
    send_command(CMD_CANCEL,    4'd1,  32'd0,     1'b0);
    send_command(CMD_UNUSED_LO, 4'd9,  32'd0,     1'b0);
    send_command(CMD_UNUSED_HI, 4'd15, DELAY_MAX, 1'b1);
    repeat (3) send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
    send_command(CMD_ARM,       4'd3,  32'd7,     1'b0);
    send_command(CMD_SUSPEND,   4'd3,  32'd0,     1'b0);

    // Zero limit: refuse every start, force arm leaves its timer stopped.
    set_limit(5'd0);
    send_command(CMD_RESUME,    4'd3,  32'd0,     1'b0);
    send_command(CMD_FORCE_ARM, 4'd2,  32'd4,     1'b1);
    send_command(CMD_ARM,       4'd4,  32'd2,     1'b0);

    // Full limit, then tighten it so a retriggerable expiry cannot reload.
    set_limit(5'd2);
    send_command(CMD_ARM,       4'd6,  32'd1,     1'b1);
    send_command(CMD_ARM,       4'd7,  32'd4,     1'b0);
    send_command(CMD_RESUME,    4'd3,  32'd0,     1'b0);  // limit reached
    set_limit(5'd1);
    send_command(CMD_TICK,      4'd0,  32'd0,     1'b0);
    set_limit(5'd31);
    send_command(CMD_RESUME,    4'd3,  32'd0,     1'b0);
    send_command(CMD_CANCEL,    4'd7,  32'd0,     1'b0);
    send_command(CMD_CANCEL,    4'd3,  32'd0,     1'b0);

    // Random phases, each under its own limit and id span.
    for (int p = 0; p < PHASES; p++) begin
      set_limit(phase_limits[p]);
      id_span = $urandom_range(3, TIMERS - 1);
      repeat (PHASE_ITEMS) random_command();
    end

    if (cmd_live) cmd_if.valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && due_count == 0) begin
      $display("timer_pool_manager_tb passed");
    end else begin
      $display("timer_pool_manager_tb failed");
    end
    $finish;
  end

endmodule

### timer_pool_manager.f
design/tpm_pkg.sv
design/tpm_if.sv
design/tpm_ctrl.sv
design/tpm_dp.sv
design/timer_pool_manager.sv
design/tpm_checker.sv
tb/timer_pool_manager_check.sv
tb/timer_pool_manager_tb.sv
